// ===== hdl/oale_pkg.sv =====
// Shared types, constants and word helpers for the ordered array list engine.
`timescale 1ns / 1ps

package oale_pkg;

  // list geometry
  localparam int CAPACITY   = 64;
  localparam int WORD_WIDTH = 32;

  // fixed beat field widths
  localparam int CMD_W  = 3;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;
  localparam int LEN_W  = 7;
  localparam int STAT_W = 2;

  // read gather tree: groups of cells OR-ed and registered, then a final OR
  localparam int OR_GROUP  = 8;
  localparam int OR_GROUPS = (CAPACITY + OR_GROUP - 1) / OR_GROUP;

  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_READ   = 3'd3,
    CMD_APPEND = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // operation that every cell applies to its entry
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SHIFT_UP,
    OP_SHIFT_DOWN,
    OP_WRITE
  } cell_op_t;

  // broadcast to the whole row of cells
  typedef struct packed {
    cell_op_t         op;
    logic             rd;
    logic [POS_W-1:0] pos;
    word_t            word;
  } cell_cmd_t;

  // beat data word to stored word (truncate or sign-extend)
  function automatic word_t to_word(input logic [DATA_W-1:0] d);
    word_t w;
    for (int b = 0; b < WORD_WIDTH; b++) begin
      w[b] = d[(b < DATA_W) ? b : DATA_W - 1];
    end
    return w;
  endfunction

  // stored word to beat data word (sign-extend or truncate)
  function automatic logic [DATA_W-1:0] from_word(input word_t w);
    logic [DATA_W-1:0] d;
    for (int b = 0; b < DATA_W; b++) begin
      d[b] = w[(b < WORD_WIDTH) ? b : WORD_WIDTH - 1];
    end
    return d;
  endfunction

endpackage

// ===== hdl/oale_cell.sv =====
// One list cell: holds one entry and moves it to or from its neighbours.
`timescale 1ns / 1ps

module oale_cell (
  input  logic                     clk,
  input  oale_pkg::cell_cmd_t      cmd,
  input  logic [oale_pkg::POS_W-1:0] idx,
  input  oale_pkg::word_t          left_word,
  input  oale_pkg::word_t          right_word,
  output oale_pkg::word_t          entry_word,
  output oale_pkg::word_t          sel_word
);

  oale_pkg::word_t entry_r;
  oale_pkg::word_t entry_nxt;

  // next entry from the broadcast command
  always_comb begin
    entry_nxt = entry_r;
    case (cmd.op)
      oale_pkg::OP_SHIFT_UP: begin
        if (idx > cmd.pos) begin
          entry_nxt = left_word;
        end else if (idx == cmd.pos) begin
          entry_nxt = cmd.word;
        end
      end
      oale_pkg::OP_SHIFT_DOWN: begin
        if (idx >= cmd.pos) begin
          entry_nxt = right_word;
        end
      end
      oale_pkg::OP_WRITE: begin
        if (idx == cmd.pos) begin
          entry_nxt = cmd.word;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  // entry storage, undefined until written
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_word = entry_r;
  // only the addressed cell shows its entry to the gather tree
  assign sel_word = (cmd.rd && (idx == cmd.pos)) ? entry_r : '0;

endmodule

// ===== hdl/oale_gather.sv =====
// Registered OR tree that collects the selected entry from the cell row.
`timescale 1ns / 1ps

module oale_gather (
  input  logic            clk,
  input  oale_pkg::word_t sel_words [oale_pkg::CAPACITY],
  output oale_pkg::word_t gathered
);

  oale_pkg::word_t partial_r   [oale_pkg::OR_GROUPS];
  oale_pkg::word_t partial_nxt [oale_pkg::OR_GROUPS];

  // first level: OR within each group of cells
  always_comb begin
    for (int g = 0; g < oale_pkg::OR_GROUPS; g++) begin
      partial_nxt[g] = '0;
      for (int m = 0; m < oale_pkg::OR_GROUP; m++) begin
        if (g * oale_pkg::OR_GROUP + m < oale_pkg::CAPACITY) begin
          partial_nxt[g] = partial_nxt[g] |
            sel_words[(g * oale_pkg::OR_GROUP + m < oale_pkg::CAPACITY) ?
                      g * oale_pkg::OR_GROUP + m : 0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int g = 0; g < oale_pkg::OR_GROUPS; g++) begin
      partial_r[g] <= partial_nxt[g];
    end
  end

  // second level: OR of the group results
  always_comb begin
    gathered = '0;
    for (int g = 0; g < oale_pkg::OR_GROUPS; g++) begin
      gathered = gathered | partial_r[g];
    end
  end

endmodule

// ===== hdl/ordered_array_list_engine.sv =====
// A result beat passes the execute state (cell update) and the gather state (gather
// tree) and is then loaded into the output register once it is free; no new input beat
// is taken until then, and the next beat is taken while an earlier result waits at the output.
// Insert, append and delete shift, and update writes, the cells of the row at once.
// Reset (synchronous, rst_n low): list length zero, no result pending, entries
// keep whatever they hold and are read only after being written.
`timescale 1ns / 1ps

module ordered_array_list_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [oale_pkg::CMD_W-1:0]  in_cmd,
  input  logic [oale_pkg::POS_W-1:0]  in_position,
  input  logic [oale_pkg::DATA_W-1:0] in_write_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [oale_pkg::STAT_W-1:0] out_status,
  output logic [oale_pkg::DATA_W-1:0] out_read_word,
  output logic [oale_pkg::LEN_W-1:0]  out_length
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_GATHER
  } state_t;

  localparam logic [oale_pkg::LEN_W-1:0] FULL_COUNT = oale_pkg::LEN_W'(oale_pkg::CAPACITY);

  state_t                        state_r, state_nxt;
  logic [oale_pkg::LEN_W-1:0]    count_r, count_nxt;
  oale_pkg::cell_op_t            op_r, op_nxt;
  logic                          rd_r, rd_nxt;
  logic [oale_pkg::POS_W-1:0]    pos_r, pos_nxt;
  oale_pkg::word_t               word_r, word_nxt;
  oale_pkg::status_t             status_r, status_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [oale_pkg::STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [oale_pkg::DATA_W-1:0]   out_read_word_r, out_read_word_nxt;
  logic [oale_pkg::LEN_W-1:0]    out_length_r, out_length_nxt;

  logic                          accept;
  oale_pkg::cell_cmd_t           cell_cmd;
  oale_pkg::word_t               entry_words [oale_pkg::CAPACITY];
  oale_pkg::word_t               sel_words   [oale_pkg::CAPACITY];
  oale_pkg::word_t               gathered;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // decode, status and sequencing
  always_comb begin
    state_nxt         = state_r;
    count_nxt         = count_r;
    op_nxt            = op_r;
    rd_nxt            = rd_r;
    pos_nxt           = pos_r;
    word_nxt          = word_r;
    status_nxt        = status_r;
    out_valid_nxt     = out_valid_r;
    out_status_nxt    = out_status_r;
    out_read_word_nxt = out_read_word_r;
    out_length_nxt    = out_length_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = oale_pkg::OP_HOLD;
          rd_nxt     = 1'b0;
          pos_nxt    = in_position;
          word_nxt   = oale_pkg::to_word(in_write_word);
          status_nxt = oale_pkg::ST_OK;
          case (oale_pkg::cmd_t'(in_cmd))
            oale_pkg::CMD_INSERT: begin
              if (count_r == FULL_COUNT) begin
                status_nxt = oale_pkg::ST_FULL;
              end else if (in_position > count_r) begin
                status_nxt = oale_pkg::ST_RANGE;
              end else begin
                op_nxt    = oale_pkg::OP_SHIFT_UP;
                count_nxt = count_r + oale_pkg::LEN_W'(1);
              end
            end
            oale_pkg::CMD_APPEND: begin
              if (count_r == FULL_COUNT) begin
                status_nxt = oale_pkg::ST_FULL;
              end else begin
                op_nxt    = oale_pkg::OP_SHIFT_UP;
                pos_nxt   = oale_pkg::POS_W'(count_r);
                count_nxt = count_r + oale_pkg::LEN_W'(1);
              end
            end
            oale_pkg::CMD_DELETE: begin
              if (count_r == '0) begin
                status_nxt = oale_pkg::ST_EMPTY;
              end else if (in_position >= count_r) begin
                status_nxt = oale_pkg::ST_RANGE;
              end else begin
                op_nxt    = oale_pkg::OP_SHIFT_DOWN;
                count_nxt = count_r - oale_pkg::LEN_W'(1);
              end
            end
            oale_pkg::CMD_UPDATE: begin
              if (count_r == '0) begin
                status_nxt = oale_pkg::ST_EMPTY;
              end else if (in_position >= count_r) begin
                status_nxt = oale_pkg::ST_RANGE;
              end else begin
                op_nxt = oale_pkg::OP_WRITE;
              end
            end
            oale_pkg::CMD_READ: begin
              if (count_r == '0) begin
                status_nxt = oale_pkg::ST_EMPTY;
              end else if (in_position >= count_r) begin
                status_nxt = oale_pkg::ST_RANGE;
              end else begin
                rd_nxt = 1'b1;
              end
            end
            oale_pkg::CMD_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              status_nxt = oale_pkg::ST_OK;
            end
          endcase
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_GATHER;
      end
      S_GATHER: begin
        // load the result once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = status_r;
          out_read_word_nxt = oale_pkg::from_word(gathered);
          out_length_nxt    = count_r;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      op_r        <= oale_pkg::OP_HOLD;
      rd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      op_r        <= op_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r           <= pos_nxt;
    word_r          <= word_nxt;
    status_r        <= status_nxt;
    out_status_r    <= out_status_nxt;
    out_read_word_r <= out_read_word_nxt;
    out_length_r    <= out_length_nxt;
  end

  // command to the row: shifts and writes live only for the execute cycle,
  // the read select stays up until the result is loaded
  always_comb begin
    cell_cmd.op   = (state_r == S_EXEC) ? op_r : oale_pkg::OP_HOLD;
    cell_cmd.rd   = ((state_r == S_EXEC) || (state_r == S_GATHER)) && rd_r;
    cell_cmd.pos  = pos_r;
    cell_cmd.word = word_r;
  end

  // row of cells
  for (genvar i = 0; i < oale_pkg::CAPACITY; i++) begin : g_cell
    oale_pkg::word_t left_w;
    oale_pkg::word_t right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = entry_words[i-1];
    end

    if (i == oale_pkg::CAPACITY - 1) begin : g_last
      assign right_w = entry_words[i];
    end else begin : g_inner_r
      assign right_w = entry_words[i+1];
    end

    oale_cell u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .idx        (oale_pkg::POS_W'(i)),
      .left_word  (left_w),
      .right_word (right_w),
      .entry_word (entry_words[i]),
      .sel_word   (sel_words[i])
    );
  end

  oale_gather u_gather (
    .clk       (clk),
    .sel_words (sel_words),
    .gathered  (gathered)
  );

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_word = out_read_word_r;
  assign out_length    = out_length_r;

endmodule

// ===== hdl/oale_checker.sv =====
// Port-level checks for the ordered array list engine, bound to the top level.
`timescale 1ns / 1ps

module oale_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [oale_pkg::CMD_W-1:0]  in_cmd,
  input logic [oale_pkg::POS_W-1:0]  in_position,
  input logic [oale_pkg::DATA_W-1:0] in_write_word,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [oale_pkg::STAT_W-1:0] out_status,
  input logic [oale_pkg::DATA_W-1:0] out_read_word,
  input logic [oale_pkg::LEN_W-1:0]  out_length
);

  // no result beat straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  // a failed command never returns data
  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != oale_pkg::ST_OK) |-> out_read_word == '0)
    else $error("read word not zero on failing status");

  // full is reported only with a full list
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == oale_pkg::ST_FULL) |->
    out_length == oale_pkg::LEN_W'(oale_pkg::CAPACITY))
    else $error("full status with list not full");

  // empty is reported only with an empty list
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == oale_pkg::ST_EMPTY) |-> out_length == '0)
    else $error("empty status with list not empty");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_read_word) && $stable(out_length))
    else $error("stalled result beat changed");

endmodule

bind ordered_array_list_engine oale_checker u_oale_checker (.*);
